// ===== rtl/core/tmm_pkg.sv =====
// Shared types, constants and helpers of the tiled matrix multiply command sequencer.
package tmm_pkg;

    // Field widths fixed by the command format.
    localparam int unsigned ADDR_W    = 48;
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned EB_W      = 7;
    localparam int unsigned CFG_IDX_W = 3;

    // Limits applied to the configuration values when they are used.
    localparam int unsigned MAX_DIM    = 4096;
    localparam int unsigned MAX_EB     = 64;
    localparam int unsigned PAGE_BYTES = 4 * 1024;

    // Tile counters hold 0 .. MAX_DIM-1.
    localparam int unsigned CNT_W = $clog2(MAX_DIM);

    // Command opcodes.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_MAC   = 2'd2,
        OP_IDLE  = 2'd3
    } op_t;

    // Tile register slots.
    typedef enum logic [1:0] {
        SLOT_A = 2'd0,
        SLOT_B = 2'd1,
        SLOT_C = 2'd2
    } slot_t;

    // Position within the per-output-tile command program.
    typedef enum logic [2:0] {
        PH_LOAD_C  = 3'd0,
        PH_LOAD_A  = 3'd1,
        PH_LOAD_B  = 3'd2,
        PH_MAC     = 3'd3,
        PH_STORE_C = 3'd4
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_BASE       = 3'd0,
        CFG_INNER_DIM    = 3'd1,
        CFG_A_ROWS       = 3'd2,
        CFG_B_COLS       = 3'd3,
        CFG_A_ELEM_BYTES = 3'd4,
        CFG_B_ELEM_BYTES = 3'd5,
        CFG_TILE_SIZE    = 3'd6
    } cfg_idx_t;

    // Which matrix base a page remainder pass belongs to.
    typedef enum logic [1:0] {
        REM_A = 2'd0,
        REM_B = 2'd1,
        REM_C = 2'd2
    } rem_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SIZE1,
        ST_SIZE2,
        ST_WAIT_A,
        ST_START_B,
        ST_WAIT_B,
        ST_START_C,
        ST_WAIT_C,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     clamp_load;
        logic     size_mul1;
        logic     size_mul2;
        logic     rem_start;
        rem_sel_t rem_sel;
        logic     base_load;
        logic     mul1;
        logic     mul2;
        logic     emit;
    } tmm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stale;
        logic rem_busy;
        logic out_full;
    } tmm_status_t;

    // Saturate a dimension into 1 .. MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    // Saturate an element size into 1 .. MAX_EB.
    function automatic logic [EB_W-1:0] clamp_eb(input logic [EB_W-1:0] v);
        logic [EB_W-1:0] r;
        if (v == '0)
            r = EB_W'(1);
        else if (v > EB_W'(MAX_EB))
            r = EB_W'(MAX_EB);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/core/tmm_page_rem.sv =====
// Remainder of a byte address by the page size, used for page rounding.
module tmm_page_rem #(
    parameter int unsigned PAGE_BYTES = tmm_pkg::PAGE_BYTES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [tmm_pkg::ADDR_W-1:0]            x,
    output logic                                  busy,
    output logic [$clog2(PAGE_BYTES + 1)-1:0]     rem
);

    localparam int unsigned REM_W   = $clog2(PAGE_BYTES + 1);
    localparam bit          IS_POW2 = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            // A power-of-two page is a plain mask, ready in the cycle after start.
            localparam logic [REM_W-1:0] MASK = REM_W'(PAGE_BYTES - 1);

            logic             busy_reg;
            logic [REM_W-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    busy_reg <= 1'b0;
                else
                    busy_reg <= start;
            end

            always_ff @(posedge clk)
            begin
                if (start)
                    rem_reg <= x[REM_W-1:0] & MASK;
            end

            assign busy = busy_reg;
            assign rem  = rem_reg;
        end else begin : g_recip
            // Remainder by reciprocal multiplication. The quotient is built from four
            // partial products, one per cycle, and a final step turns the low bits of
            // the quotient into the remainder. Busy clears when the remainder is written.
            localparam int unsigned ADDR_W  = tmm_pkg::ADDR_W;
            localparam int unsigned HALF_W  = ADDR_W / 2;
            localparam int unsigned RECIP_W = ADDR_W + 1;
            localparam int unsigned RLO_W   = RECIP_W - HALF_W;
            localparam int unsigned PROD_W  = HALF_W + RLO_W;
            localparam int unsigned ACC_W   = ADDR_W + RECIP_W;
            localparam int unsigned SHIFT   = ADDR_W + REM_W;
            localparam logic [127:0] RECIP_WIDE =
                ((128'd1 << SHIFT) + 128'(PAGE_BYTES) - 128'd1) / 128'(PAGE_BYTES);
            localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_WIDE);
            localparam logic [REM_W-1:0]   PAGE_R    = REM_W'(PAGE_BYTES);
            localparam logic [2:0]         LAST_STEP = 3'd4;

            logic                busy_reg;
            logic [2:0]          step_reg;
            logic [ADDR_W-1:0]   x_reg;
            logic [ACC_W-1:0]    acc_reg;
            logic [REM_W-1:0]    rem_reg;
            logic [HALF_W-1:0]   mul_a;
            logic [RLO_W-1:0]    mul_b;
            logic [PROD_W-1:0]   prod;
            logic [ACC_W-1:0]    term;
            logic [REM_W-1:0]    quot_lo;
            logic [2*REM_W-1:0]  quot_page;

            // Halves of the address and of the reciprocal for this step.
            assign mul_a = step_reg[1] ? x_reg[ADDR_W-1:HALF_W] : x_reg[HALF_W-1:0];
            assign mul_b = step_reg[0] ? RLO_W'(RECIP[RECIP_W-1:RLO_W]) : RECIP[RLO_W-1:0];
            assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

            // Partial product placed at its weight in the full product.
            always_comb
            begin
                unique case (step_reg[1:0])
                    2'd0:    term = ACC_W'(prod);
                    2'd1:    term = ACC_W'(prod) << RLO_W;
                    2'd2:    term = ACC_W'(prod) << HALF_W;
                    2'd3:    term = ACC_W'(prod) << (HALF_W + RLO_W);
                endcase
            end

            // Only the low quotient bits matter, since the remainder is below the page.
            assign quot_lo   = acc_reg[SHIFT +: REM_W];
            assign quot_page = (2 * REM_W)'(quot_lo) * (2 * REM_W)'(PAGE_R);

            // Step count and busy flag.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= '0;
                end
                else if (start)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
                else if (busy_reg)
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        busy_reg <= 1'b0;
                end
            end

            // Product accumulation, then the remainder in the final step.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    x_reg   <= x;
                    acc_reg <= '0;
                end
                else if (busy_reg)
                begin
                    if (step_reg == LAST_STEP)
                        rem_reg <= x_reg[REM_W-1:0] - quot_page[REM_W-1:0];
                    else
                        acc_reg <= acc_reg + term;
                end
            end

            assign busy = busy_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

// ===== rtl/core/tmm_dpath.sv =====
// Datapath: configuration, derived bases, program counters and address arithmetic.
module tmm_dpath #(
    parameter int unsigned PAGE_BYTES = tmm_pkg::PAGE_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmm_pkg::ADDR_W-1:0]        cfg_data,
    input  logic                              restart,
    input  tmm_pkg::tmm_cmd_t                 cmd,
    output tmm_pkg::tmm_status_t              status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        opcode,
    output logic [1:0]                        tile_slot,
    output logic [tmm_pkg::ADDR_W-1:0]        address,
    output logic [tmm_pkg::DIM_W-1:0]         tile_cols,
    output logic [tmm_pkg::DIM_W-1:0]         tile_rows,
    output logic [tmm_pkg::DIM_W-1:0]         row_stride,
    output logic [tmm_pkg::EB_W-1:0]          elem_bytes,
    output logic                              last
);

    localparam int unsigned ADDR_W  = tmm_pkg::ADDR_W;
    localparam int unsigned DIM_W   = tmm_pkg::DIM_W;
    localparam int unsigned EB_W    = tmm_pkg::EB_W;
    localparam int unsigned CNT_W   = tmm_pkg::CNT_W;
    localparam int unsigned REM_W   = $clog2(PAGE_BYTES + 1);
    localparam int unsigned AREA_W  = 2 * DIM_W;
    localparam int unsigned SIZE_W  = AREA_W + EB_W;
    localparam int unsigned OFF_W   = CNT_W + DIM_W + 1;
    localparam int unsigned SCALE_W = DIM_W + EB_W;
    localparam int unsigned CHK_W   = 2 * DIM_W;

    // Configuration registers.
    logic [ADDR_W-1:0] a_base_reg;
    logic [DIM_W-1:0]  inner_dim_reg;
    logic [DIM_W-1:0]  a_rows_reg;
    logic [DIM_W-1:0]  b_cols_reg;
    logic [EB_W-1:0]   a_eb_reg;
    logic [EB_W-1:0]   b_eb_reg;
    logic [DIM_W-1:0]  tile_size_reg;
    logic              stale_reg;

    // Values derived from the configuration.
    logic [DIM_W-1:0]  kd_reg;
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [DIM_W-1:0]  ts_reg;
    logic [EB_W-1:0]   ae_reg;
    logic [EB_W-1:0]   be_reg;
    logic [EB_W-1:0]   ce_reg;
    logic [AREA_W-1:0] kr_reg;
    logic [AREA_W-1:0] ck_reg;
    logic [SIZE_W-1:0] size_a_reg;
    logic [SIZE_W-1:0] size_b_reg;
    logic [ADDR_W-1:0] rem_x_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [ADDR_W-1:0] c_addr_reg;

    // Program position.
    logic [CNT_W-1:0]  tile_row_reg;
    logic [CNT_W-1:0]  tile_col_reg;
    logic [CNT_W-1:0]  inner_step_reg;
    tmm_pkg::phase_t   phase_reg;
    logic              finished_reg;

    // Address arithmetic stages.
    logic [OFF_W-1:0]   sum1_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [ADDR_W-1:0]  prod_reg;
    logic               col_done_reg;
    logic               row_done_reg;
    logic               k_done_reg;

    // Result register.
    logic              out_valid_reg;
    tmm_pkg::op_t      opcode_reg;
    tmm_pkg::slot_t    slot_reg;
    logic [ADDR_W-1:0] address_reg;
    logic [DIM_W-1:0]  tile_edge_reg;
    logic [DIM_W-1:0]  stride_reg;
    logic [EB_W-1:0]   eb_reg;
    logic              last_reg;

    // Page remainder unit.
    logic              rem_busy;
    logic [REM_W-1:0]  rem_val;
    logic [ADDR_W-1:0] rem_x_sel;
    logic [ADDR_W-1:0] floor_addr;
    logic [ADDR_W-1:0] ceil_addr;

    // Next values.
    logic [OFF_W-1:0]   sum1_next;
    logic [SCALE_W-1:0] scale_next;
    logic               col_done_next;
    logic               row_done_next;
    logic               k_done_next;
    logic [CNT_W-1:0]   m1;
    logic [DIM_W-1:0]   m2;
    logic [CNT_W-1:0]   m3;
    logic [EB_W-1:0]    e_sel;
    logic [ADDR_W-1:0]  base_sel;

    tmm_pkg::op_t      opcode_next;
    tmm_pkg::slot_t    slot_next;
    logic [ADDR_W-1:0] address_next;
    logic [DIM_W-1:0]  tile_edge_next;
    logic [DIM_W-1:0]  stride_next;
    logic [EB_W-1:0]   eb_next;
    logic              last_next;
    logic [CNT_W-1:0]  tile_row_next;
    logic [CNT_W-1:0]  tile_col_next;
    logic [CNT_W-1:0]  inner_step_next;
    tmm_pkg::phase_t   phase_next;
    logic              finished_next;

    // Configuration writes; any write marks the derived values out of date.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_base_reg    <= '0;
            inner_dim_reg <= DIM_W'(1);
            a_rows_reg    <= DIM_W'(1);
            b_cols_reg    <= DIM_W'(1);
            a_eb_reg      <= EB_W'(1);
            b_eb_reg      <= EB_W'(1);
            tile_size_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmm_pkg::CFG_A_BASE:       a_base_reg    <= cfg_data;
                tmm_pkg::CFG_INNER_DIM:    inner_dim_reg <= cfg_data[DIM_W-1:0];
                tmm_pkg::CFG_A_ROWS:       a_rows_reg    <= cfg_data[DIM_W-1:0];
                tmm_pkg::CFG_B_COLS:       b_cols_reg    <= cfg_data[DIM_W-1:0];
                tmm_pkg::CFG_A_ELEM_BYTES: a_eb_reg      <= cfg_data[EB_W-1:0];
                tmm_pkg::CFG_B_ELEM_BYTES: b_eb_reg      <= cfg_data[EB_W-1:0];
                tmm_pkg::CFG_TILE_SIZE:    tile_size_reg <= cfg_data[DIM_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stale_reg <= 1'b1;
        else if (cfg_we)
            stale_reg <= 1'b1;
        else if (cmd.base_load && (cmd.rem_sel == tmm_pkg::REM_C))
            stale_reg <= 1'b0;
    end

    // Operand of the page remainder pass and the two roundings of it.
    always_comb
    begin
        unique case (cmd.rem_sel)
            tmm_pkg::REM_B: rem_x_sel = a_addr_reg + ADDR_W'(size_a_reg);
            tmm_pkg::REM_C: rem_x_sel = b_addr_reg + ADDR_W'(size_b_reg);
            default:        rem_x_sel = a_base_reg;
        endcase
    end

    assign floor_addr = rem_x_reg - ADDR_W'(rem_val);
    assign ceil_addr  = (rem_val != '0) ? floor_addr + ADDR_W'(PAGE_BYTES) : floor_addr;

    tmm_page_rem #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.rem_start),
        .x     (rem_x_sel),
        .busy  (rem_busy),
        .rem   (rem_val)
    );

    // Derived sizes and matrix bases, refreshed after a configuration change.
    always_ff @(posedge clk)
    begin
        if (cmd.clamp_load)
        begin
            kd_reg   <= tmm_pkg::clamp_dim(inner_dim_reg);
            rows_reg <= tmm_pkg::clamp_dim(a_rows_reg);
            cols_reg <= tmm_pkg::clamp_dim(b_cols_reg);
            ts_reg   <= tmm_pkg::clamp_dim(tile_size_reg);
            ae_reg   <= tmm_pkg::clamp_eb(a_eb_reg);
            be_reg   <= tmm_pkg::clamp_eb(b_eb_reg);
            if (tmm_pkg::clamp_eb(a_eb_reg) > tmm_pkg::clamp_eb(b_eb_reg))
                ce_reg <= tmm_pkg::clamp_eb(a_eb_reg);
            else
                ce_reg <= tmm_pkg::clamp_eb(b_eb_reg);
        end
        if (cmd.size_mul1)
        begin
            kr_reg <= AREA_W'(kd_reg) * AREA_W'(rows_reg);
            ck_reg <= AREA_W'(cols_reg) * AREA_W'(kd_reg);
        end
        if (cmd.size_mul2)
        begin
            size_a_reg <= SIZE_W'(kr_reg) * SIZE_W'(ae_reg);
            size_b_reg <= SIZE_W'(ck_reg) * SIZE_W'(be_reg);
        end
        if (cmd.rem_start)
            rem_x_reg <= rem_x_sel;
        if (cmd.base_load)
        begin
            unique case (cmd.rem_sel)
                tmm_pkg::REM_B: b_addr_reg <= ceil_addr;
                tmm_pkg::REM_C: c_addr_reg <= ceil_addr;
                default:        a_addr_reg <= floor_addr;
            endcase
        end
    end

    // Operands of the tile address: base + (m1 * m2 + m3) * (tile * element bytes).
    always_comb
    begin
        unique case (phase_reg)
            tmm_pkg::PH_LOAD_A:
            begin
                m1       = tile_row_reg;
                m2       = kd_reg;
                m3       = inner_step_reg;
                e_sel    = ae_reg;
                base_sel = a_addr_reg;
            end
            tmm_pkg::PH_LOAD_B:
            begin
                m1       = inner_step_reg;
                m2       = cols_reg;
                m3       = tile_col_reg;
                e_sel    = be_reg;
                base_sel = b_addr_reg;
            end
            default:
            begin
                m1       = tile_row_reg;
                m2       = cols_reg;
                m3       = tile_col_reg;
                e_sel    = ce_reg;
                base_sel = c_addr_reg;
            end
        endcase
    end

    // First stage: tile offset, tile scale and the column end test.
    assign sum1_next     = OFF_W'(m1) * OFF_W'(m2) + OFF_W'(m3);
    assign scale_next    = SCALE_W'(ts_reg) * SCALE_W'(e_sel);
    assign col_done_next = ((CHK_W'(tile_col_reg) + CHK_W'(1)) * CHK_W'(ts_reg))
                           >= CHK_W'(cols_reg);

    // Second stage: byte offset and the row and inner end tests.
    assign row_done_next = ((CHK_W'(tile_row_reg) + CHK_W'(1)) * CHK_W'(ts_reg))
                           >= CHK_W'(rows_reg);
    assign k_done_next   = ((CHK_W'(inner_step_reg) + CHK_W'(1)) * CHK_W'(ts_reg))
                           >= CHK_W'(kd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            sum1_reg     <= sum1_next;
            scale_reg    <= scale_next;
            col_done_reg <= col_done_next;
        end
        if (cmd.mul2)
        begin
            prod_reg     <= ADDR_W'(sum1_reg) * ADDR_W'(scale_reg);
            row_done_reg <= row_done_next;
            k_done_reg   <= k_done_next;
        end
    end

    // Command for the current program position and the position after it.
    always_comb
    begin
        opcode_next     = tmm_pkg::OP_IDLE;
        slot_next       = tmm_pkg::SLOT_A;
        address_next    = '0;
        tile_edge_next  = '0;
        stride_next     = '0;
        eb_next         = '0;
        last_next       = 1'b0;
        tile_row_next   = tile_row_reg;
        tile_col_next   = tile_col_reg;
        inner_step_next = inner_step_reg;
        phase_next      = phase_reg;
        finished_next   = finished_reg;
        if (!finished_reg)
        begin
            unique case (phase_reg)
                tmm_pkg::PH_LOAD_C:
                begin
                    opcode_next     = tmm_pkg::OP_LOAD;
                    slot_next       = tmm_pkg::SLOT_C;
                    address_next    = base_sel + prod_reg;
                    tile_edge_next  = ts_reg;
                    stride_next     = cols_reg;
                    eb_next         = ce_reg;
                    inner_step_next = '0;
                    phase_next      = tmm_pkg::PH_LOAD_A;
                end
                tmm_pkg::PH_LOAD_A:
                begin
                    opcode_next    = tmm_pkg::OP_LOAD;
                    slot_next      = tmm_pkg::SLOT_A;
                    address_next   = base_sel + prod_reg;
                    tile_edge_next = ts_reg;
                    stride_next    = kd_reg;
                    eb_next        = ae_reg;
                    phase_next     = tmm_pkg::PH_LOAD_B;
                end
                tmm_pkg::PH_LOAD_B:
                begin
                    opcode_next    = tmm_pkg::OP_LOAD;
                    slot_next      = tmm_pkg::SLOT_B;
                    address_next   = base_sel + prod_reg;
                    tile_edge_next = ts_reg;
                    stride_next    = cols_reg;
                    eb_next        = be_reg;
                    phase_next     = tmm_pkg::PH_MAC;
                end
                tmm_pkg::PH_MAC:
                begin
                    opcode_next     = tmm_pkg::OP_MAC;
                    slot_next       = tmm_pkg::SLOT_C;
                    inner_step_next = inner_step_reg + 1'b1;
                    phase_next      = k_done_reg ? tmm_pkg::PH_STORE_C : tmm_pkg::PH_LOAD_A;
                end
                tmm_pkg::PH_STORE_C:
                begin
                    opcode_next     = tmm_pkg::OP_STORE;
                    slot_next       = tmm_pkg::SLOT_C;
                    address_next    = base_sel + prod_reg;
                    tile_edge_next  = ts_reg;
                    stride_next     = cols_reg;
                    eb_next         = ce_reg;
                    last_next       = row_done_reg && col_done_reg;
                    inner_step_next = '0;
                    phase_next      = tmm_pkg::PH_LOAD_C;
                    if (col_done_reg)
                    begin
                        tile_col_next = '0;
                        tile_row_next = tile_row_reg + 1'b1;
                        if (row_done_reg)
                            finished_next = 1'b1;
                    end
                    else
                    begin
                        tile_col_next = tile_col_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = tmm_pkg::PH_LOAD_C;
                end
            endcase
        end
    end

    // Program position: restart when a request with restart set is accepted, advance when a command is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_row_reg   <= '0;
            tile_col_reg   <= '0;
            inner_step_reg <= '0;
            phase_reg      <= tmm_pkg::PH_LOAD_C;
            finished_reg   <= 1'b0;
        end
        else if (cmd.accept && restart)
        begin
            tile_row_reg   <= '0;
            tile_col_reg   <= '0;
            inner_step_reg <= '0;
            phase_reg      <= tmm_pkg::PH_LOAD_C;
            finished_reg   <= 1'b0;
        end
        else if (cmd.emit)
        begin
            tile_row_reg   <= tile_row_next;
            tile_col_reg   <= tile_col_next;
            inner_step_reg <= inner_step_next;
            phase_reg      <= phase_next;
            finished_reg   <= finished_next;
        end
    end

    // Result register: filled on issue, emptied when the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            opcode_reg    <= opcode_next;
            slot_reg      <= slot_next;
            address_reg   <= address_next;
            tile_edge_reg <= tile_edge_next;
            stride_reg    <= stride_next;
            eb_reg        <= eb_next;
            last_reg      <= last_next;
        end
    end

    assign status.stale    = stale_reg;
    assign status.rem_busy = rem_busy;
    assign status.out_full = out_valid_reg && out_stall;

    assign out_valid  = out_valid_reg;
    assign opcode     = opcode_reg;
    assign tile_slot  = slot_reg;
    assign address    = address_reg;
    assign tile_cols  = tile_edge_reg;
    assign tile_rows  = tile_edge_reg;
    assign row_stride = stride_reg;
    assign elem_bytes = eb_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/core/tmm_ctrl.sv =====
// Controller: sequences the datapath through one request at a time.
module tmm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tmm_pkg::tmm_status_t  status,
    output tmm_pkg::tmm_cmd_t     cmd
);

    tmm_pkg::ctrl_state_t state_reg;
    tmm_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tmm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rem_sel = tmm_pkg::REM_A;
        in_stall    = 1'b1;
        unique case (state_reg)
            tmm_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = status.stale ? tmm_pkg::ST_CLAMP : tmm_pkg::ST_MUL1;
            end
            tmm_pkg::ST_CLAMP:
            begin
                cmd.clamp_load = 1'b1;
                state_next     = tmm_pkg::ST_SIZE1;
            end
            tmm_pkg::ST_SIZE1:
            begin
                cmd.size_mul1 = 1'b1;
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = tmm_pkg::REM_A;
                state_next    = tmm_pkg::ST_SIZE2;
            end
            tmm_pkg::ST_SIZE2:
            begin
                cmd.size_mul2 = 1'b1;
                state_next    = tmm_pkg::ST_WAIT_A;
            end
            tmm_pkg::ST_WAIT_A:
            begin
                cmd.rem_sel = tmm_pkg::REM_A;
                if (!status.rem_busy)
                begin
                    cmd.base_load = 1'b1;
                    state_next    = tmm_pkg::ST_START_B;
                end
            end
            tmm_pkg::ST_START_B:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = tmm_pkg::REM_B;
                state_next    = tmm_pkg::ST_WAIT_B;
            end
            tmm_pkg::ST_WAIT_B:
            begin
                cmd.rem_sel = tmm_pkg::REM_B;
                if (!status.rem_busy)
                begin
                    cmd.base_load = 1'b1;
                    state_next    = tmm_pkg::ST_START_C;
                end
            end
            tmm_pkg::ST_START_C:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = tmm_pkg::REM_C;
                state_next    = tmm_pkg::ST_WAIT_C;
            end
            tmm_pkg::ST_WAIT_C:
            begin
                cmd.rem_sel = tmm_pkg::REM_C;
                if (!status.rem_busy)
                begin
                    cmd.base_load = 1'b1;
                    state_next    = tmm_pkg::ST_MUL1;
                end
            end
            tmm_pkg::ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = tmm_pkg::ST_MUL2;
            end
            tmm_pkg::ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = tmm_pkg::ST_EMIT;
            end
            tmm_pkg::ST_EMIT:
            begin
                // Hold the command until the result register is free.
                if (!status.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tiled_matmul_command_sequencer.sv =====
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   restart
// command   out        out_valid / out_stall opcode, tile_slot, address, tile_cols,
//                                            tile_rows, row_stride, elem_bytes, last
// config    in         cfg_we                cfg_index, cfg_data
//
// Each request passes through acceptance, two multiply stages for the tile address
// and end-of-loop tests, and issue into the command register.
// The first request after a configuration write also rebuilds the matrix bases
// with three page remainder passes in turn: a plain mask when PAGE_BYTES is a power
// of two, otherwise reciprocal multiplication.
// Reset returns the program to its first command and marks the bases for rebuild.
// A stalled command holds in the output register while the next request is
// accepted; that request waits at issue until the register frees.
module tiled_matmul_command_sequencer #(
    parameter int unsigned PAGE_BYTES = tmm_pkg::PAGE_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmm_pkg::ADDR_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        opcode,
    output logic [1:0]                        tile_slot,
    output logic [tmm_pkg::ADDR_W-1:0]        address,
    output logic [tmm_pkg::DIM_W-1:0]         tile_cols,
    output logic [tmm_pkg::DIM_W-1:0]         tile_rows,
    output logic [tmm_pkg::DIM_W-1:0]         row_stride,
    output logic [tmm_pkg::EB_W-1:0]          elem_bytes,
    output logic                              last
);

    tmm_pkg::tmm_cmd_t    cmd;
    tmm_pkg::tmm_status_t status;

    // Sequencing of each request.
    tmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Configuration, program position and address arithmetic.
    tmm_dpath #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .restart    (restart),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .opcode     (opcode),
        .tile_slot  (tile_slot),
        .address    (address),
        .tile_cols  (tile_cols),
        .tile_rows  (tile_rows),
        .row_stride (row_stride),
        .elem_bytes (elem_bytes),
        .last       (last)
    );

endmodule
